>>> rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and word types of the quadratic root solver.
// Used by the interfaces and by every qrs module; depends on nothing.
package qrs_pkg;

    localparam int COEF_W = 16;                // Q8.8 coefficient
    localparam int OUT_W  = 32;                // Q16.16 root
    localparam int NB_W   = 32;                // -b scaled by 2^15
    localparam int DISC_W = 35;                // signed discriminant
    localparam int DMAG_W = 34;                // discriminant magnitude
    localparam int ROOT_W = 32;                // integer square root
    localparam int RAD_W  = 2 * ROOT_W;        // radicand, |d| shifted up by 30
    localparam int REM_W  = ROOT_W + 4;        // square root remainder
    localparam int NUM_W  = 35;                // rounded dividend 2|n| + |a|
    localparam int DEN_W  = COEF_W + 1;        // divisor 2|a|
    localparam int QREM_W = DEN_W + 1;         // division remainder
    localparam int LANES  = 2;                 // two quotients per word

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TWO  = 2'd1,
        KIND_ONE  = 2'd2,
        KIND_CPLX = 2'd3
    } t_kind;

    // Sideband that travels beside the square root.
    typedef struct packed {
        t_kind                     kind;
        logic signed [COEF_W-1:0]  a;
        logic signed [NB_W-1:0]    nb;
    } t_meta;

    // One quotient lane: result sign and dividend, later the quotient.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
    } t_lane;

    // Word that travels through the divider.
    typedef struct packed {
        t_kind                  kind;
        logic [DEN_W-1:0]       den;
        t_lane [LANES-1:0]      lane;
    } t_divw;

endpackage

>>> rtl/core/qrs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for coefficient words and root words.
// Depends on qrs_pkg for the field widths.
interface qrs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qrs_pkg::COEF_W-1:0]    coef_a;
    logic signed [qrs_pkg::COEF_W-1:0]    coef_b;
    logic signed [qrs_pkg::COEF_W-1:0]    coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           root_kind;
    logic signed [qrs_pkg::OUT_W-1:0]     root_first;
    logic signed [qrs_pkg::OUT_W-1:0]     root_second;
    logic                                 saturated;

    modport source (output valid, output root_kind, output root_first,
                    output root_second, output saturated, input ready);
    modport sink   (input valid, input root_kind, input root_first,
                    input root_second, input saturated, output ready);
endinterface

>>> rtl/core/qrs_disc.sv
`timescale 1ns / 1ps
// Two-stage discriminant unit: products, then d = b*b - 4ac and the root kind.
// Depends on qrs_pkg.
module qrs_disc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_c,
    output logic                              o_vld,
    output qrs_pkg::t_meta                    o_meta,
    output logic [qrs_pkg::DMAG_W-1:0]        o_mag
);
    logic                                r_vld1;
    logic signed [2*qrs_pkg::COEF_W-1:0] r_bb;
    logic signed [2*qrs_pkg::COEF_W-1:0] r_ac;
    logic signed [qrs_pkg::COEF_W-1:0]   r_a1;
    logic signed [qrs_pkg::NB_W-1:0]     r_nb1;
    logic signed [qrs_pkg::NB_W-1:0]     n_nb;
    logic signed [qrs_pkg::DISC_W-1:0]   n_d;
    logic [qrs_pkg::DISC_W-1:0]          n_abs;
    qrs_pkg::t_kind                      n_kind;
    logic                                r_vld2;
    qrs_pkg::t_meta                      r_meta2;
    logic [qrs_pkg::DMAG_W-1:0]          r_mag2;

    // The negated linear term in units of 2^-23.
    assign n_nb = -(qrs_pkg::NB_W'(i_b) <<< 15);

    // First stage: the two products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
        if (i_en) begin
            r_bb  <= i_b * i_b;
            r_ac  <= i_a * i_c;
            r_a1  <= i_a;
            r_nb1 <= n_nb;
        end
    end

    // Second stage: exact discriminant, its magnitude and the kind of roots.
    always_comb begin
        n_d   = qrs_pkg::DISC_W'(r_bb) - (qrs_pkg::DISC_W'(r_ac) <<< 2);
        n_abs = n_d[qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-n_d) : qrs_pkg::DISC_W'(n_d);
        if (r_a1 == '0) begin
            n_kind = qrs_pkg::KIND_NONE;
        end else if (n_d == '0) begin
            n_kind = qrs_pkg::KIND_ONE;
        end else if (n_d[qrs_pkg::DISC_W-1]) begin
            n_kind = qrs_pkg::KIND_CPLX;
        end else begin
            n_kind = qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
        if (i_en) begin
            r_meta2.kind <= n_kind;
            r_meta2.a    <= r_a1;
            r_meta2.nb   <= r_nb1;
            r_mag2       <= n_abs[qrs_pkg::DMAG_W-1:0];
        end
    end

    assign o_vld  = r_vld2;
    assign o_meta = r_meta2;
    assign o_mag  = r_mag2;
endmodule

>>> rtl/core/qrs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of |d| * 2^30, one root bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  qrs_pkg::t_meta              i_meta,
    input  logic [qrs_pkg::DMAG_W-1:0]  i_mag,
    output logic                        o_vld,
    output qrs_pkg::t_meta              o_meta,
    output logic [qrs_pkg::ROOT_W-1:0]  o_root
);
    localparam int NS = qrs_pkg::ROOT_W;

    logic                        r_vld  [NS];
    qrs_pkg::t_meta              r_meta [NS];
    logic [qrs_pkg::RAD_W-1:0]   r_rad  [NS];
    logic [qrs_pkg::REM_W-1:0]   r_rem  [NS];
    logic [qrs_pkg::ROOT_W-1:0]  r_root [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic                        s_vld;
        qrs_pkg::t_meta              s_meta;
        logic [qrs_pkg::RAD_W-1:0]   s_rad;
        logic [qrs_pkg::REM_W-1:0]   s_rem;
        logic [qrs_pkg::ROOT_W-1:0]  s_root;
        logic [qrs_pkg::REM_W-1:0]   n_sh;
        logic [qrs_pkg::REM_W-1:0]   n_trial;
        logic                        n_ge;

        // Stage input: the unit's input for the first stage, else the stage before.
        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_meta = i_meta;
            assign s_rad  = {i_mag, {(qrs_pkg::RAD_W - qrs_pkg::DMAG_W){1'b0}}};
            assign s_rem  = '0;
            assign s_root = '0;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_meta = r_meta[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign n_sh    = {s_rem[qrs_pkg::REM_W-3:0], s_rad[qrs_pkg::RAD_W-1 -: 2]};
        assign n_trial = qrs_pkg::REM_W'({s_root, 2'b01});
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
            if (i_en) begin
                r_meta[k] <= s_meta;
                r_rad[k]  <= s_rad << 2;
                r_rem[k]  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root[k] <= {s_root[qrs_pkg::ROOT_W-2:0], n_ge};
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_meta = r_meta[NS-1];
    assign o_root = r_root[NS-1];
endmodule

>>> rtl/core/qrs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, two lanes over a shared divisor, one bit per stage.
// Depends on qrs_pkg.
module qrs_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  qrs_pkg::t_divw i_word,
    output logic           o_vld,
    output qrs_pkg::t_divw o_word
);
    localparam int NS = qrs_pkg::NUM_W;

    logic                        r_vld  [NS];
    qrs_pkg::t_divw              r_word [NS];
    logic [qrs_pkg::QREM_W-1:0]  r_rem  [NS][qrs_pkg::LANES];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           s_vld;
        qrs_pkg::t_divw s_word;
        qrs_pkg::t_divw n_word;
        logic [qrs_pkg::QREM_W-1:0] s_rem [qrs_pkg::LANES];
        logic [qrs_pkg::QREM_W-1:0] n_rem [qrs_pkg::LANES];

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_word = i_word;
            for (genvar l = 0; l < qrs_pkg::LANES; l++) begin : g_l
                assign s_rem[l] = '0;
            end
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_word = r_word[k-1];
            for (genvar l = 0; l < qrs_pkg::LANES; l++) begin : g_l
                assign s_rem[l] = r_rem[k-1][l];
            end
        end

        // Shift one dividend bit into the remainder; the quotient bit enters below.
        always_comb begin
            logic [qrs_pkg::QREM_W-1:0] sh;
            logic                       ge;
            n_word = s_word;
            for (int l = 0; l < qrs_pkg::LANES; l++) begin
                sh = {s_rem[l][qrs_pkg::QREM_W-2:0], s_word.lane[l].num[qrs_pkg::NUM_W-1]};
                ge = (sh >= qrs_pkg::QREM_W'(s_word.den));
                n_rem[l] = ge ? (sh - qrs_pkg::QREM_W'(s_word.den)) : sh;
                n_word.lane[l].num = {s_word.lane[l].num[qrs_pkg::NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
            if (i_en) begin
                r_word[k] <= n_word;
                for (int l = 0; l < qrs_pkg::LANES; l++) begin
                    r_rem[k][l] <= n_rem[l];
                end
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_word = r_word[NS-1];
endmodule

>>> rtl/core/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
// Quadratic root solver top level: discriminant, square root, dividers, output.
// Depends on qrs_pkg, qrs_if, qrs_disc, qrs_sqrt and qrs_div.

// The unit takes one coefficient word (a, b, c in signed Q8.8) per clock and
// returns one root word per coefficient word, in order, after the discriminant
// stages, the square root stages (one root bit per stage), the register that
// forms the rounded dividends, the two parallel dividers (one quotient bit per
// stage) and the register for sign, saturation and the output word. The whole
// pipeline advances together; it holds only while a root word waits at the
// output and is not taken, and then the input is not ready.
module quadratic_root_solver_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qrs_in_if.sink       i_in,
    qrs_out_if.source    o_out
);
    logic                        w_en;
    logic                        w_disc_vld;
    qrs_pkg::t_meta              w_disc_meta;
    logic [qrs_pkg::DMAG_W-1:0]  w_disc_mag;
    logic                        w_sqrt_vld;
    qrs_pkg::t_meta              w_sqrt_meta;
    logic [qrs_pkg::ROOT_W-1:0]  w_sqrt_root;
    logic                        w_div_vld;
    qrs_pkg::t_divw              w_div_word;
    logic                        r_prep_vld;
    qrs_pkg::t_divw              r_prep;
    qrs_pkg::t_divw              n_prep;
    logic                        r_out_vld;
    logic [1:0]                  r_out_kind;
    logic [qrs_pkg::OUT_W-1:0]   r_out_root [qrs_pkg::LANES];
    logic                        r_out_sat;
    logic [qrs_pkg::OUT_W-1:0]   n_root [qrs_pkg::LANES];
    logic                        n_sat;

    // The pipeline moves whenever the output register is free or being taken.
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    qrs_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_a     (i_in.coef_a),
        .i_b     (i_in.coef_b),
        .i_c     (i_in.coef_c),
        .o_vld   (w_disc_vld),
        .o_meta  (w_disc_meta),
        .o_mag   (w_disc_mag)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_disc_vld),
        .i_meta  (w_disc_meta),
        .i_mag   (w_disc_mag),
        .o_vld   (w_sqrt_vld),
        .o_meta  (w_sqrt_meta),
        .o_root  (w_sqrt_root)
    );

    // Pick the two numerators for the root kind and form the rounded dividends.
    always_comb begin
        logic signed [qrs_pkg::DISC_W-1:0] nb;
        logic signed [qrs_pkg::DISC_W-1:0] s;
        logic signed [qrs_pkg::DISC_W-1:0] n [qrs_pkg::LANES];
        logic [qrs_pkg::DISC_W-1:0]        mag;
        logic [qrs_pkg::COEF_W-1:0]        md;
        nb = qrs_pkg::DISC_W'(w_sqrt_meta.nb);
        s  = qrs_pkg::DISC_W'(w_sqrt_root);
        md = w_sqrt_meta.a[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-w_sqrt_meta.a)
                                              : qrs_pkg::COEF_W'(w_sqrt_meta.a);
        case (w_sqrt_meta.kind)
            qrs_pkg::KIND_TWO: begin
                n[0] = nb + s;
                n[1] = nb - s;
            end
            qrs_pkg::KIND_CPLX: begin
                n[0] = nb;
                n[1] = s;
            end
            default: begin
                n[0] = nb;
                n[1] = nb;
            end
        endcase
        n_prep.kind = w_sqrt_meta.kind;
        n_prep.den  = {md, 1'b0};
        for (int l = 0; l < qrs_pkg::LANES; l++) begin
            mag = n[l][qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-n[l]) : qrs_pkg::DISC_W'(n[l]);
            n_prep.lane[l].neg = n[l][qrs_pkg::DISC_W-1] ^ w_sqrt_meta.a[qrs_pkg::COEF_W-1];
            n_prep.lane[l].num = {mag[qrs_pkg::NUM_W-2:0], 1'b0} + qrs_pkg::NUM_W'(md);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else if (w_en) begin
            r_prep_vld <= w_sqrt_vld;
        end
        if (w_en) begin
            r_prep <= n_prep;
        end
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_prep_vld),
        .i_word  (r_prep),
        .o_vld   (w_div_vld),
        .o_word  (w_div_word)
    );

    // Apply the sign and clip each quotient to the Q16.16 range.
    always_comb begin
        logic [qrs_pkg::NUM_W-1:0] q;
        n_sat = 1'b0;
        for (int l = 0; l < qrs_pkg::LANES; l++) begin
            q = w_div_word.lane[l].num;
            if (w_div_word.lane[l].neg) begin
                if (q > (qrs_pkg::NUM_W'(1) << (qrs_pkg::OUT_W - 1))) begin
                    n_root[l] = {1'b1, {(qrs_pkg::OUT_W-1){1'b0}}};
                    n_sat     = 1'b1;
                end else begin
                    n_root[l] = qrs_pkg::OUT_W'(-q);
                end
            end else begin
                if (q > ((qrs_pkg::NUM_W'(1) << (qrs_pkg::OUT_W - 1)) - 1'b1)) begin
                    n_root[l] = {1'b0, {(qrs_pkg::OUT_W-1){1'b1}}};
                    n_sat     = 1'b1;
                end else begin
                    n_root[l] = q[qrs_pkg::OUT_W-1:0];
                end
            end
        end
        if (w_div_word.kind == qrs_pkg::KIND_NONE) begin
            n_root[0] = '0;
            n_root[1] = '0;
            n_sat     = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
        if (w_en) begin
            r_out_kind    <= w_div_word.kind;
            r_out_root[0] <= n_root[0];
            r_out_root[1] <= n_root[1];
            r_out_sat     <= n_sat;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.root_kind   = r_out_kind;
    assign o_out.root_first  = r_out_root[0];
    assign o_out.root_second = r_out_root[1];
    assign o_out.saturated   = r_out_sat;

    // A word that is not quadratic carries zero roots and no saturation.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.root_kind == qrs_pkg::KIND_NONE) |->
        (o_out.root_first == '0 && o_out.root_second == '0 && !o_out.saturated))
        else $error("not-quadratic word with nonzero fields");

    // A double root repeats itself in both fields.
    a_one_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.root_kind == qrs_pkg::KIND_ONE) |->
        (o_out.root_first == o_out.root_second))
        else $error("double root fields differ");

    // Saturation shows up as a clipped value in one of the fields.
    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
        (o_out.root_first == 32'sh7FFF_FFFF || o_out.root_first == 32'sh8000_0000 ||
         o_out.root_second == 32'sh7FFF_FFFF || o_out.root_second == 32'sh8000_0000))
        else $error("saturation flag without clipped root");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_prep_vld))
        else $error("valid word after reset");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for quadratic_root_solver_unit: random and directed coefficient words,
// a bit-exact root predictor and an in-order checker. Depends on qrs_pkg and qrs_if.
module tb;

    typedef struct packed {
        logic signed [qrs_pkg::COEF_W-1:0] a;
        logic signed [qrs_pkg::COEF_W-1:0] b;
        logic signed [qrs_pkg::COEF_W-1:0] c;
    } t_coef;

    typedef struct packed {
        logic [1:0]                       kind;
        logic signed [qrs_pkg::OUT_W-1:0] first;
        logic signed [qrs_pkg::OUT_W-1:0] second;
        logic                             sat;
    } t_roots;

    localparam int WATCH_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qrs_in_if  coef_ch ();
    qrs_out_if root_ch ();

    quadratic_root_solver_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (coef_ch.sink),
        .o_out   (root_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_coef  pending_coefs[$];
    t_roots expected_roots[$];
    int     err_count = 0;
    int     roots_seen = 0;
    int     kind_seen[4] = '{0, 0, 0, 0};
    int     sat_seen = 0;
    int     idle_cycles = 0;
    bit     stim_done = 0;
    bit     busy_phase = 0;
    bit     coef_taken = 0;

    // Integer square root, bit by bit.
    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded (ties away from zero), saturated quotient in Q16.16.
    function automatic logic [31:0] round_div(longint num, longint den, inout logic sat);
        logic neg;
        longint unsigned mn, md, q;
        neg = (num < 0) != (den < 0);
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        q = (2 * mn + md) / (2 * md);
        if (q == 0) return 0;
        if (neg) begin
            if (q > 64'd2147483648) begin
                q = 64'd2147483648;
                sat = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            sat = 1'b1;
        end
        return 32'(q);
    endfunction

    function automatic t_roots solve_roots(t_coef w);
        t_roots r;
        longint a, b, c, d, nb, s;
        logic sat;
        a = w.a;
        b = w.b;
        c = w.c;
        sat = 1'b0;
        r = '0;
        if (a == 0) begin
            r.kind = qrs_pkg::KIND_NONE;
            return r;
        end
        d = b * b - 4 * a * c;
        nb = -b * 32768;
        if (d > 0) begin
            s = isqrt(64'(d) << 30);
            r.kind = qrs_pkg::KIND_TWO;
            r.first = round_div(nb + s, a, sat);
            r.second = round_div(nb - s, a, sat);
        end else if (d == 0) begin
            r.kind = qrs_pkg::KIND_ONE;
            r.first = round_div(nb, a, sat);
            r.second = r.first;
        end else begin
            s = isqrt(64'(-d) << 30);
            r.kind = qrs_pkg::KIND_CPLX;
            r.first = round_div(nb, a, sat);
            r.second = round_div(s, a, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic bit idle_now();
        return !busy_phase && ($urandom_range(99) < 29);
    endfunction

    // Remember whether the presented word was taken at the last rising edge.
    always @(posedge i_clk) begin
        coef_taken <= coef_ch.valid && coef_ch.ready;
    end

    // Driver: presents the oldest pending word and the root ready, changes on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            coef_ch.valid <= 1'b0;
        end else if (!coef_ch.valid || coef_taken) begin
            if (pending_coefs.size() > 0 && !idle_now()) begin
                t_coef w;
                w = pending_coefs.pop_front();
                coef_ch.valid  <= 1'b1;
                coef_ch.coef_a <= w.a;
                coef_ch.coef_b <= w.b;
                coef_ch.coef_c <= w.c;
            end else begin
                coef_ch.valid <= 1'b0;
            end
        end
        root_ch.ready <= i_rst_n && !idle_now();
    end

    // Monitor: records accepted coefficients and checks accepted roots.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (coef_ch.valid && coef_ch.ready)
                expected_roots.push_back(solve_roots({coef_ch.coef_a, coef_ch.coef_b,
                                                      coef_ch.coef_c}));
            if (root_ch.valid && root_ch.ready) begin
                roots_seen++;
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected root word", 1, 0);
                end else begin
                    t_roots e;
                    e = expected_roots.pop_front();
                    kind_seen[e.kind]++;
                    if (e.sat) sat_seen++;
                    if (root_ch.root_kind !== e.kind)
                        report_mismatch("root_kind", root_ch.root_kind, e.kind);
                    if (root_ch.root_first !== e.first)
                        report_mismatch("root_first", root_ch.root_first, e.first);
                    if (root_ch.root_second !== e.second)
                        report_mismatch("root_second", root_ch.root_second, e.second);
                    if (root_ch.saturated !== e.sat)
                        report_mismatch("saturated", root_ch.saturated, e.sat);
                end
            end
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", expected_roots.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'($urandom_range(0, 511)) - 16'd256;
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2: return 16'($urandom_range(1, 3)) << $urandom_range(13);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_coef w;
        int n;
        coef_ch.valid = 1'b0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;
        root_ch.ready = 1'b0;
        // Directed: extremes, degenerate a, double root, complex pair, saturation.
        pending_coefs.push_back('{16'sh0000, 16'sh0100, 16'sh0100});
        pending_coefs.push_back('{16'sh0000, 16'sh7fff, 16'sh8000});
        pending_coefs.push_back('{16'sh0100, 16'sh0000, 16'shff00});
        pending_coefs.push_back('{16'sh0100, 16'shfe00, 16'sh0100});
        pending_coefs.push_back('{16'sh0100, 16'sh0000, 16'sh0100});
        pending_coefs.push_back('{16'sh0001, 16'sh7fff, 16'sh0000});
        pending_coefs.push_back('{16'sh0001, 16'sh8000, 16'sh7fff});
        pending_coefs.push_back('{16'shffff, 16'sh7fff, 16'sh7fff});
        pending_coefs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_coefs.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_coefs.push_back('{16'sh8000, 16'sh0000, 16'sh7fff});
        pending_coefs.push_back('{16'sh7fff, 16'sh0000, 16'sh8000});
        pending_coefs.push_back('{16'shff00, 16'sh0400, 16'shfc00});
        pending_coefs.push_back('{16'sh0200, 16'sh0000, 16'sh0000});
        pending_coefs.push_back('{16'shffff, 16'sh0000, 16'sh0001});
        pending_coefs.push_back('{16'sh0003, 16'sh0001, 16'sh0000});
        pending_coefs.push_back('{16'shfffd, 16'shffff, 16'sh0000});
        pending_coefs.push_back('{16'sh0001, 16'sh0002, 16'sh0001});
        // Random words, some with exact double roots.
        for (n = 0; n < 900; n++) begin
            w.a = pick_coef();
            w.b = pick_coef();
            w.c = pick_coef();
            if ($urandom_range(9) == 0) begin
                w.a = 16'($urandom_range(1, 64));
                w.b = 16'(2 * $urandom_range(0, 16)) * w.a;
                w.c = 16'((longint'(w.b) * w.b) / (4 * w.a));
            end
            pending_coefs.push_back(w);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // A pressure-free stretch partway through.
        wait (pending_coefs.size() < 500);
        busy_phase = 1;
        wait (pending_coefs.size() < 350);
        busy_phase = 0;
        wait (pending_coefs.size() == 0 && !coef_ch.valid);
        wait (expected_roots.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("checked %0d root words: %0d degenerate, %0d two real, %0d one real,",
                 roots_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d complex, %0d saturated", kind_seen[3], sat_seen);
        if (err_count == 0 && expected_roots.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_if.sv
rtl/core/qrs_disc.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver_unit.sv
tb/tb.sv
